// File: rtl/nrc_pkg.sv
// Shared types, character codes and small helpers for the RMC sentence checker.
`timescale 1ns / 1ps
`default_nettype none
package nrc_pkg;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [3:0] FIELD_LAST  = 4'd15;
	localparam logic [2:0] CHAR_LAST   = 3'd7;
	localparam logic [2:0] TIME_DIGITS = 3'd6;
	localparam logic [3:0] FIELD_TIME  = 4'd1;
	localparam logic [3:0] FIELD_STAT  = 4'd2;
	localparam logic [1:0] HEX_BAD     = 2'd3;

	localparam logic [6:0] HOURS_DAY = 7'd24;
	localparam logic [6:0] MIN_MAX   = 7'd59;
	localparam logic [6:0] SEC_MAX   = 7'd60;

	// Sentence-end event from the parser.
	typedef struct packed {
		logic       fire;
		logic       ok;
		logic       have_time;
		logic [4:0] hh;
		logic [5:0] mm;
		logic [5:0] ss;
	} nrc_event_t;

	// One result beat.
	typedef struct packed {
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [4:0] hours;
		logic       have_time;
		logic       accepted;
	} nrc_result_t;

	// Returns {valid, value} for an ASCII hex digit of either case.
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	// Two BCD digits to binary, 0 to 99.
	function automatic logic [6:0] dec2(input logic [3:0] t, input logic [3:0] o);
		return ({3'd0, t} << 3) + ({3'd0, t} << 1) + {3'd0, o};
	endfunction

	// Modulo 24 for values below 120.
	function automatic logic [4:0] mod24(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		if (r >= 7'd96) begin
			r = r - 7'd96;
		end else if (r >= 7'd72) begin
			r = r - 7'd72;
		end else if (r >= 7'd48) begin
			r = r - 7'd48;
		end else if (r >= HOURS_DAY) begin
			r = r - HOURS_DAY;
		end
		return r[4:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/nmea_rmc_checksum_time_extract_top.sv
// Top level: input register, parser, hour offset and output register.
// A sentence-ending character goes from the input register into the output register.
// Throughput: one character per cycle; a sentence-ending character waits in the input
// register while a result is unread, but a character that ends no sentence moves on even
// then. The parse state updates once per character from the input register.
// Reset (arst_n low): pipeline empty, parse state and stored time cleared, hour offset 8.
`timescale 1ns / 1ps
`default_nettype none
module nmea_rmc_checksum_time_extract_top
	import nrc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata    // [0] accepted, [1] have_time, [6:2] hours,
	                                         // [12:7] minutes, [18:13] seconds, rest zero
);

	logic [4:0]  hour_offset_q;
	logic [7:0]  ch_s1;
	logic        vld_s1;
	logic        out_vld_q;
	nrc_result_t out_q, out_n;
	nrc_event_t  ev;
	logic        out_free, step, load_out;

	nrc_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (ch_s1),
		.ev     (ev)
	);

	assign out_free      = !out_vld_q || m_axis_tready;
	assign step          = vld_s1 && (!ev.fire || out_free);
	assign load_out      = step && ev.fire;
	assign s_axis_tready = !vld_s1 || step;

	always_comb begin
		out_n.accepted  = ev.ok;
		out_n.have_time = ev.have_time;
		if (ev.have_time) begin
			out_n.hours   = mod24(7'(ev.hh) + 7'(hour_offset_q));
			out_n.minutes = ev.mm;
			out_n.seconds = ev.ss;
		end else begin
			out_n.hours   = '0;
			out_n.minutes = '0;
			out_n.seconds = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_offset_q <= 5'd8;
			vld_s1        <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				hour_offset_q <= cfg_wdata;
			end
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1 <= s_axis_tdata;
		end
		if (load_out) begin
			out_q <= out_n;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, out_q};

	a_hours_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (7'(out_q.hours) < HOURS_DAY) && (7'(out_q.minutes) <= MIN_MAX)
			&& (7'(out_q.seconds) <= SEC_MAX))
		else $error("result time out of range");

	a_no_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_q.have_time) |->
			(out_q.hours == 5'd0 && out_q.minutes == 6'd0 && out_q.seconds == 6'd0))
		else $error("time fields set before any sentence was accepted");

	a_acc_has_time: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.accepted) |-> out_q.have_time)
		else $error("accepted sentence without stored time");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_axis_tready) |-> !load_out)
		else $error("result register overwritten while full");

endmodule
`default_nettype wire

// File: rtl/nrc_parse.sv
// Per-character parse state: fields, checksum, status and time capture.
`timescale 1ns / 1ps
`default_nettype none
module nrc_parse
	import nrc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] ch,
	output nrc_event_t      ev
);

	logic             in_sent_q, in_sent_n;
	logic [3:0]       field_q, field_n, field_b;
	logic [2:0]       cif_q, cif_n, cif_b;
	logic [7:0]       rx_q, rx_n, rx_b;
	logic [7:0]       xs_q, xs_n, xs_b;
	logic             star_q, star_n, star_b;
	logic [7:0]       hv_q, hv_n, hv_b;
	logic [1:0]       hd_q, hd_n, hd_b;
	logic             st_q, st_n, st_b;
	logic [5:0][3:0]  bcd_q, bcd_n, bcd_b;
	logic             bad_q, bad_n, bad_b;
	logic [4:0]       hh_q, hh_n;
	logic [5:0]       mm_q, mm_n;
	logic [5:0]       ss_q, ss_n;
	logic             tv_q, tv_n;

	logic       ws, is_star, is_comma, is_digit, short_time, ok;
	logic [4:0] hex;
	logic [6:0] mm_raw, ss_raw;

	assign ws = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
	assign is_star  = (ch == CH_STAR);
	assign is_comma = (ch == CH_COMMA);
	assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
	assign hex      = hex_of(ch);

	assign short_time = (field_q == FIELD_TIME) && (cif_q < TIME_DIGITS);
	assign ok = st_q && star_q && (hd_q != 2'd0) && (hd_q != HEX_BAD) && (hv_q == xs_q);
	assign mm_raw = dec2(bcd_q[3], bcd_q[2]);
	assign ss_raw = dec2(bcd_q[1], bcd_q[0]);

	always_comb begin
		// A new sentence starts from cleared state; the first character is not in the XOR.
		if (in_sent_q) begin
			field_b = field_q;
			cif_b   = cif_q;
			rx_b    = is_star ? rx_q : (rx_q ^ ch);
			xs_b    = xs_q;
			star_b  = star_q;
			hv_b    = hv_q;
			hd_b    = hd_q;
			st_b    = st_q;
			bcd_b   = bcd_q;
			bad_b   = bad_q;
		end else begin
			field_b = '0;
			cif_b   = '0;
			rx_b    = '0;
			xs_b    = '0;
			star_b  = 1'b0;
			hv_b    = '0;
			hd_b    = '0;
			st_b    = 1'b0;
			bcd_b   = '0;
			bad_b   = 1'b0;
		end

		in_sent_n = in_sent_q;
		field_n   = field_b;
		cif_n     = cif_b;
		rx_n      = rx_b;
		xs_n      = xs_b;
		star_n    = star_b;
		hv_n      = hv_b;
		hd_n      = hd_b;
		st_n      = st_b;
		bcd_n     = bcd_b;
		bad_n     = bad_b;
		hh_n      = hh_q;
		mm_n      = mm_q;
		ss_n      = ss_q;
		tv_n      = tv_q;

		if (ws) begin
			if (in_sent_q) begin
				in_sent_n = 1'b0;
				if (ok) begin
					tv_n = 1'b1;
					if (bad_q || short_time) begin
						hh_n = '0;
						mm_n = '0;
						ss_n = '0;
					end else begin
						hh_n = mod24(dec2(bcd_q[5], bcd_q[4]));
						mm_n = (mm_raw > MIN_MAX) ? MIN_MAX[5:0] : mm_raw[5:0];
						ss_n = (ss_raw > SEC_MAX) ? SEC_MAX[5:0] : ss_raw[5:0];
					end
				end
			end
		end else begin
			in_sent_n = 1'b1;
			if (is_star) begin
				xs_n   = rx_b;
				star_n = 1'b1;
				hv_n   = '0;
				hd_n   = '0;
				if (field_b != 4'd0 || cif_b != 3'd0) begin
					rx_n = rx_b ^ ch;
				end
			end else if (star_b) begin
				if (hex[4] && hd_b < 2'd2) begin
					hv_n = {hv_b[3:0], hex[3:0]};
					hd_n = hd_b + 2'd1;
				end else begin
					hd_n = HEX_BAD;
				end
			end

			if (is_comma) begin
				if (field_b == FIELD_TIME && cif_b < TIME_DIGITS) begin
					bad_n = 1'b1;
				end
				if (field_b != FIELD_LAST) begin
					field_n = field_b + 4'd1;
				end
				cif_n = '0;
			end else begin
				if (field_b == FIELD_TIME && cif_b < TIME_DIGITS) begin
					if (is_digit && !bad_b) begin
						bcd_n = {bcd_b[4:0], ch[3:0]};
					end else begin
						bad_n = 1'b1;
					end
				end
				if (field_b == FIELD_STAT) begin
					st_n = (cif_b == 3'd0) && (ch == CH_A);
				end
				if (cif_b != CHAR_LAST) begin
					cif_n = cif_b + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b0;
			field_q   <= '0;
			cif_q     <= '0;
			rx_q      <= '0;
			xs_q      <= '0;
			star_q    <= 1'b0;
			hv_q      <= '0;
			hd_q      <= '0;
			st_q      <= 1'b0;
			bcd_q     <= '0;
			bad_q     <= 1'b0;
			hh_q      <= '0;
			mm_q      <= '0;
			ss_q      <= '0;
			tv_q      <= 1'b0;
		end else if (step) begin
			in_sent_q <= in_sent_n;
			field_q   <= field_n;
			cif_q     <= cif_n;
			rx_q      <= rx_n;
			xs_q      <= xs_n;
			star_q    <= star_n;
			hv_q      <= hv_n;
			hd_q      <= hd_n;
			st_q      <= st_n;
			bcd_q     <= bcd_n;
			bad_q     <= bad_n;
			hh_q      <= hh_n;
			mm_q      <= mm_n;
			ss_q      <= ss_n;
			tv_q      <= tv_n;
		end
	end

	always_comb begin
		ev.fire      = ws && in_sent_q;
		ev.ok        = ok;
		ev.have_time = tv_n;
		ev.hh        = hh_n;
		ev.mm        = mm_n;
		ev.ss        = ss_n;
	end

endmodule
`default_nettype wire
